// ===== rtl/bacs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounding-box autocentre and shrink package
// Shared types, register map, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bacs_pkg;

  localparam int IN_W       = 19;
  localparam int REAL_W     = 16;
  localparam int STEP_W     = 14;
  localparam int FACTOR_W   = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int MARGIN_W = 10;
  localparam int CENTER_W = 18;
  localparam int MSTEP_W  = 13;
  localparam int TOL_W    = 14;

  localparam logic [15:0]         SHRINK_Q16 = 16'd65012;
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPTION_ON         = 3'd0,
    REG_EDGE_MARGIN       = 3'd1,
    REG_TOP_EDGE_MARGIN   = 3'd2,
    REG_HYSTERESIS_MARGIN = 3'd3,
    REG_TARGET_CENTER_X   = 3'd4,
    REG_TARGET_CENTER_Y   = 3'd5,
    REG_MOVE_STEP         = 3'd6,
    REG_CENTER_TOLERANCE  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_MOVE   = 2'd1,
    ACT_SHRINK = 2'd2
  } action_e;

  typedef struct packed {
    logic                option_on;
    logic [MARGIN_W-1:0] edge_margin;
    logic [MARGIN_W-1:0] top_edge_margin;
    logic [MARGIN_W-1:0] hysteresis_margin;
    logic [CENTER_W-1:0] target_center_x;
    logic [CENTER_W-1:0] target_center_y;
    logic [MSTEP_W-1:0]  move_step;
    logic [TOL_W-1:0]    center_tolerance;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    option_on:         1'b1,
    edge_margin:       10'd20,
    top_edge_margin:   10'd40,
    hysteresis_margin: 10'd20,
    target_center_x:   18'd8192,
    target_center_y:   18'd8192,
    move_step:         13'd16,
    center_tolerance:  14'd32
  };

endpackage

`default_nettype wire

// ===== rtl/bbox_autocenter_shrink.sv =====
// ----------------------------------------------------------------------------
// Bounding-box autocentre and shrink controller
// Top level: configuration registers, box fold, scaling and decision stages.
// ----------------------------------------------------------------------------
// The block takes one line segment per clock cycle while in_stall_o is low and
// folds both of its endpoints into the frame's bounding box; a segment with
// frame_start set clears the box first. A segment with frame_end set yields
// one result via the input, fold, scaling and decision registers, and results
// may also leave once per cycle while out_stall_i is low. Other segments
// yield no result. Configuration writes are always accepted and take effect
// on the next cycle; they should only be made while no frame is in flight.
`default_nettype none

module bbox_autocenter_shrink
  import bacs_pkg::*;
#(
  parameter int WINDOW_WIDTH   = 1024,
  parameter int WINDOW_HEIGHT  = 1024,
  parameter int ACCURACY_SCALE = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [IN_W-1:0]  x_pos_i,
  input  wire logic signed [IN_W-1:0]  y_pos_i,
  input  wire logic signed [IN_W-1:0]  delta_x_i,
  input  wire logic signed [IN_W-1:0]  delta_y_i,
  input  wire logic                    frame_start_i,
  input  wire logic                    frame_end_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [REAL_W-1:0]     box_min_x_real_o,
  output logic signed [REAL_W-1:0]     box_min_y_real_o,
  output logic signed [REAL_W-1:0]     box_max_x_real_o,
  output logic signed [REAL_W-1:0]     box_max_y_real_o,
  output logic                         rescale_on_o,
  output logic [1:0]                   action_o,
  output logic signed [STEP_W-1:0]     step_x_o,
  output logic signed [STEP_W-1:0]     step_y_o,
  output logic [FACTOR_W-1:0]          scale_factor_o
);

  localparam int RST_MIN_X = WINDOW_WIDTH * ACCURACY_SCALE;
  localparam int RST_MIN_Y = WINDOW_HEIGHT * ACCURACY_SCALE;
  localparam int RST_MAX   = (RST_MIN_X > RST_MIN_Y) ? RST_MIN_X : RST_MIN_Y;
  localparam int BOX_W     = (RST_MAX < (1 << 19)) ? 20 : $clog2(RST_MAX + 1) + 1;

  cfg_t cfg;

  logic                    fold_valid, scale_ready;
  logic signed [BOX_W-1:0] min_x, min_y, max_x, max_y;

  logic                    scale_valid, decide_ready;
  logic signed [BOX_W-1:0] rmin_x, rmin_y, rmax_x, rmax_y, cen_x, cen_y;

  bacs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bacs_box_fold #(
    .BOX_W     (BOX_W),
    .RST_MIN_X (RST_MIN_X),
    .RST_MIN_Y (RST_MIN_Y)
  ) u_box_fold (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .delta_x_i     (delta_x_i),
    .delta_y_i     (delta_y_i),
    .frame_start_i (frame_start_i),
    .frame_end_i   (frame_end_i),
    .valid_o       (fold_valid),
    .ready_i       (scale_ready),
    .min_x_o       (min_x),
    .min_y_o       (min_y),
    .max_x_o       (max_x),
    .max_y_o       (max_y)
  );

  bacs_scale #(
    .BOX_W          (BOX_W),
    .ACCURACY_SCALE (ACCURACY_SCALE)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (fold_valid),
    .ready_o  (scale_ready),
    .min_x_i  (min_x),
    .min_y_i  (min_y),
    .max_x_i  (max_x),
    .max_y_i  (max_y),
    .valid_o  (scale_valid),
    .ready_i  (decide_ready),
    .rmin_x_o (rmin_x),
    .rmin_y_o (rmin_y),
    .rmax_x_o (rmax_x),
    .rmax_y_o (rmax_y),
    .cen_x_o  (cen_x),
    .cen_y_o  (cen_y)
  );

  bacs_decide #(
    .BOX_W         (BOX_W),
    .WINDOW_WIDTH  (WINDOW_WIDTH),
    .WINDOW_HEIGHT (WINDOW_HEIGHT)
  ) u_decide (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .valid_i          (scale_valid),
    .ready_o          (decide_ready),
    .rmin_x_i         (rmin_x),
    .rmin_y_i         (rmin_y),
    .rmax_x_i         (rmax_x),
    .rmax_y_i         (rmax_y),
    .cen_x_i          (cen_x),
    .cen_y_i          (cen_y),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .box_min_x_real_o (box_min_x_real_o),
    .box_min_y_real_o (box_min_y_real_o),
    .box_max_x_real_o (box_max_x_real_o),
    .box_max_y_real_o (box_max_y_real_o),
    .rescale_on_o     (rescale_on_o),
    .action_o         (action_o),
    .step_x_o         (step_x_o),
    .step_y_o         (step_y_o),
    .scale_factor_o   (scale_factor_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bacs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the eight control registers written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module bacs_cfg_regs
  import bacs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_OPTION_ON:         cfg_d.option_on         = cfg_data_i[0];
        REG_EDGE_MARGIN:       cfg_d.edge_margin       = cfg_data_i[MARGIN_W-1:0];
        REG_TOP_EDGE_MARGIN:   cfg_d.top_edge_margin   = cfg_data_i[MARGIN_W-1:0];
        REG_HYSTERESIS_MARGIN: cfg_d.hysteresis_margin = cfg_data_i[MARGIN_W-1:0];
        REG_TARGET_CENTER_X:   cfg_d.target_center_x   = cfg_data_i[CENTER_W-1:0];
        REG_TARGET_CENTER_Y:   cfg_d.target_center_y   = cfg_data_i[CENTER_W-1:0];
        REG_MOVE_STEP:         cfg_d.move_step         = cfg_data_i[MSTEP_W-1:0];
        REG_CENTER_TOLERANCE:  cfg_d.center_tolerance  = cfg_data_i[TOL_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bacs_box_fold.sv =====
// ----------------------------------------------------------------------------
// Segment input register and bounding-box fold
// Registers each segment, folds both endpoints into the running box and
// captures the box of every frame-end segment for evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module bacs_box_fold
  import bacs_pkg::*;
#(
  parameter int BOX_W     = 20,
  parameter int RST_MIN_X = 16384,
  parameter int RST_MIN_Y = 16384
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [IN_W-1:0]  x_pos_i,
  input  wire logic signed [IN_W-1:0]  y_pos_i,
  input  wire logic signed [IN_W-1:0]  delta_x_i,
  input  wire logic signed [IN_W-1:0]  delta_y_i,
  input  wire logic                    frame_start_i,
  input  wire logic                    frame_end_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output logic signed [BOX_W-1:0]      min_x_o,
  output logic signed [BOX_W-1:0]      min_y_o,
  output logic signed [BOX_W-1:0]      max_x_o,
  output logic signed [BOX_W-1:0]      max_y_o
);

  localparam logic signed [BOX_W-1:0] BOX_RST_MIN_X = BOX_W'(RST_MIN_X);
  localparam logic signed [BOX_W-1:0] BOX_RST_MIN_Y = BOX_W'(RST_MIN_Y);

  function automatic logic signed [BOX_W-1:0] sext(input logic signed [IN_W-1:0] v);
    return $signed({{(BOX_W-IN_W){v[IN_W-1]}}, v});
  endfunction

  function automatic logic signed [BOX_W-1:0] smin(input logic signed [BOX_W-1:0] a,
                                                    input logic signed [BOX_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [BOX_W-1:0] smax(input logic signed [BOX_W-1:0] a,
                                                    input logic signed [BOX_W-1:0] b);
    return (b > a) ? b : a;
  endfunction

  logic                   s0_valid_q;
  logic signed [IN_W-1:0] s0_x_q, s0_y_q, s0_dx_q, s0_dy_q;
  logic                   s0_fs_q, s0_fe_q;

  logic signed [BOX_W-1:0] box_min_x_q, box_min_y_q, box_max_x_q, box_max_y_q;
  logic signed [BOX_W-1:0] box_min_x_d, box_min_y_d, box_max_x_d, box_max_y_d;
  logic signed [BOX_W-1:0] base_min_x, base_min_y, base_max_x, base_max_y;
  logic signed [BOX_W-1:0] pt_x0, pt_x1, pt_y0, pt_y1;

  logic                    s1_valid_q;
  logic signed [BOX_W-1:0] s1_min_x_q, s1_min_y_q, s1_max_x_q, s1_max_y_q;

  logic ready0, ready1, s0_go;

  assign ready1     = !s1_valid_q || ready_i;
  assign s0_go      = s0_valid_q && (ready1 || !s0_fe_q);
  assign ready0     = !s0_valid_q || s0_go;
  assign in_stall_o = !ready0;

  always_comb begin
    base_min_x = s0_fs_q ? BOX_RST_MIN_X : box_min_x_q;
    base_min_y = s0_fs_q ? BOX_RST_MIN_Y : box_min_y_q;
    base_max_x = s0_fs_q ? '0 : box_max_x_q;
    base_max_y = s0_fs_q ? '0 : box_max_y_q;
    pt_x0      = sext(s0_x_q);
    pt_y0      = sext(s0_y_q);
    pt_x1      = sext(s0_x_q) + sext(s0_dx_q);
    pt_y1      = sext(s0_y_q) + sext(s0_dy_q);
    box_min_x_d = smin(smin(base_min_x, pt_x0), pt_x1);
    box_max_x_d = smax(smax(base_max_x, pt_x0), pt_x1);
    box_min_y_d = smin(smin(base_min_y, pt_y0), pt_y1);
    box_max_y_d = smax(smax(base_max_y, pt_y0), pt_y1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      box_min_x_q <= BOX_RST_MIN_X;
      box_min_y_q <= BOX_RST_MIN_Y;
      box_max_x_q <= '0;
      box_max_y_q <= '0;
    end else begin
      if (ready0) begin
        s0_valid_q <= in_valid_i;
      end
      if (ready1) begin
        s1_valid_q <= s0_valid_q && s0_fe_q;
      end
      if (s0_go) begin
        box_min_x_q <= box_min_x_d;
        box_min_y_q <= box_min_y_d;
        box_max_x_q <= box_max_x_d;
        box_max_y_q <= box_max_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready0) begin
      s0_x_q  <= x_pos_i;
      s0_y_q  <= y_pos_i;
      s0_dx_q <= delta_x_i;
      s0_dy_q <= delta_y_i;
      s0_fs_q <= frame_start_i;
      s0_fe_q <= frame_end_i;
    end
    if (ready1) begin
      s1_min_x_q <= box_min_x_d;
      s1_min_y_q <= box_min_y_d;
      s1_max_x_q <= box_max_x_d;
      s1_max_y_q <= box_max_y_d;
    end
  end

  assign valid_o = s1_valid_q;
  assign min_x_o = s1_min_x_q;
  assign min_y_o = s1_min_y_q;
  assign max_x_o = s1_max_x_q;
  assign max_y_o = s1_max_y_q;

endmodule

`default_nettype wire

// ===== rtl/bacs_scale.sv =====
// ----------------------------------------------------------------------------
// Accuracy-to-window scaling stage
// Divides the box by the accuracy scale with a reciprocal multiply and forms
// the box centre, both registered for the decision stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bacs_scale
  import bacs_pkg::*;
#(
  parameter int BOX_W          = 20,
  parameter int ACCURACY_SCALE = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire logic signed [BOX_W-1:0] min_x_i,
  input  wire logic signed [BOX_W-1:0] min_y_i,
  input  wire logic signed [BOX_W-1:0] max_x_i,
  input  wire logic signed [BOX_W-1:0] max_y_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output logic signed [BOX_W-1:0]      rmin_x_o,
  output logic signed [BOX_W-1:0]      rmin_y_o,
  output logic signed [BOX_W-1:0]      rmax_x_o,
  output logic signed [BOX_W-1:0]      rmax_y_o,
  output logic signed [BOX_W-1:0]      cen_x_o,
  output logic signed [BOX_W-1:0]      cen_y_o
);

  // Exact for every magnitude below 2**BOX_W with a shift of BOX_W + log2 of the scale.
  localparam int DIV_SHIFT = BOX_W + $clog2(ACCURACY_SCALE);
  localparam int MUL_W     = BOX_W + 1;
  localparam int PROD_W    = 2 * BOX_W + 1;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((64'd1 << DIV_SHIFT) + 64'(ACCURACY_SCALE) - 64'd1) / 64'(ACCURACY_SCALE));

  function automatic logic signed [BOX_W-1:0] div_acc(input logic signed [BOX_W-1:0] v);
    logic [BOX_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [BOX_W-1:0]  quo;
    mag  = v[BOX_W-1] ? (~v + 1'b1) : v;
    prod = {{(BOX_W+1){1'b0}}, mag} * {{BOX_W{1'b0}}, DIV_MUL};
    quo  = BOX_W'(prod >> DIV_SHIFT);
    return $signed(v[BOX_W-1] ? (~quo + 1'b1) : quo);
  endfunction

  function automatic logic signed [BOX_W-1:0] half_sum(input logic signed [BOX_W-1:0] a,
                                                        input logic signed [BOX_W-1:0] b);
    logic signed [BOX_W:0] sum;
    logic signed [BOX_W:0] adj;
    sum = $signed({a[BOX_W-1], a}) + $signed({b[BOX_W-1], b});
    adj = sum + $signed({{BOX_W{1'b0}}, sum[BOX_W]});
    return $signed(adj[BOX_W:1]);
  endfunction

  logic s2_valid_q;
  logic signed [BOX_W-1:0] rmin_x_q, rmin_y_q, rmax_x_q, rmax_y_q, cen_x_q, cen_y_q;

  assign ready_o = !s2_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (ready_o) begin
      s2_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rmin_x_q <= div_acc(min_x_i);
      rmin_y_q <= div_acc(min_y_i);
      rmax_x_q <= div_acc(max_x_i);
      rmax_y_q <= div_acc(max_y_i);
      cen_x_q  <= half_sum(min_x_i, max_x_i);
      cen_y_q  <= half_sum(min_y_i, max_y_i);
    end
  end

  assign valid_o  = s2_valid_q;
  assign rmin_x_o = rmin_x_q;
  assign rmin_y_o = rmin_y_q;
  assign rmax_x_o = rmax_x_q;
  assign rmax_y_o = rmax_y_q;
  assign cen_x_o  = cen_x_q;
  assign cen_y_o  = cen_y_q;

endmodule

`default_nettype wire

// ===== rtl/bacs_decide.sv =====
// ----------------------------------------------------------------------------
// Rescale decision and result register
// Applies the margin hysteresis, chooses a centring move or a shrink, keeps
// the cumulative Q1.16 factor and holds the result for the output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bacs_decide
  import bacs_pkg::*;
#(
  parameter int BOX_W         = 20,
  parameter int WINDOW_WIDTH  = 1024,
  parameter int WINDOW_HEIGHT = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  cfg_t                         cfg_i,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire logic signed [BOX_W-1:0] rmin_x_i,
  input  wire logic signed [BOX_W-1:0] rmin_y_i,
  input  wire logic signed [BOX_W-1:0] rmax_x_i,
  input  wire logic signed [BOX_W-1:0] rmax_y_i,
  input  wire logic signed [BOX_W-1:0] cen_x_i,
  input  wire logic signed [BOX_W-1:0] cen_y_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [REAL_W-1:0]     box_min_x_real_o,
  output logic signed [REAL_W-1:0]     box_min_y_real_o,
  output logic signed [REAL_W-1:0]     box_max_x_real_o,
  output logic signed [REAL_W-1:0]     box_max_y_real_o,
  output logic                         rescale_on_o,
  output logic [1:0]                   action_o,
  output logic signed [STEP_W-1:0]     step_x_o,
  output logic signed [STEP_W-1:0]     step_y_o,
  output logic [FACTOR_W-1:0]          scale_factor_o
);

  localparam int CMP_W  = BOX_W + 2;
  localparam int PROD_W = FACTOR_W + 16;
  localparam logic signed [CMP_W-1:0] WIN_W_C = CMP_W'(WINDOW_WIDTH);
  localparam logic signed [CMP_W-1:0] WIN_H_C = CMP_W'(WINDOW_HEIGHT);
  localparam logic signed [BOX_W-1:0] SAT_HI  = BOX_W'(32767);
  localparam logic signed [BOX_W-1:0] SAT_LO  = -BOX_W'(32768);

  function automatic logic signed [CMP_W-1:0] sx(input logic signed [BOX_W-1:0] v);
    return $signed({{(CMP_W-BOX_W){v[BOX_W-1]}}, v});
  endfunction

  function automatic logic signed [REAL_W-1:0] sat16(input logic signed [BOX_W-1:0] v);
    logic signed [BOX_W-1:0] r;
    r = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return r[REAL_W-1:0];
  endfunction

  function automatic logic signed [CMP_W-1:0] clamp_step(input logic signed [CMP_W-1:0] d,
                                                          input logic signed [CMP_W-1:0] s);
    logic signed [CMP_W-1:0] r;
    if (d > s) begin
      r = s;
    end else if (d < -s) begin
      r = -s;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic signed [CMP_W-1:0] sabs(input logic signed [CMP_W-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  logic                mode_q, mode_d;
  logic [FACTOR_W-1:0] factor_q, factor_d;

  logic                       out_valid_q;
  logic signed [REAL_W-1:0]   rmin_x_q, rmin_y_q, rmax_x_q, rmax_y_q;
  logic                       mode_out_q;
  action_e                    action_q, action_d;
  logic signed [STEP_W-1:0]   step_x_q, step_y_q;
  logic [FACTOR_W-1:0]        factor_out_q;

  logic signed [CMP_W-1:0] m, tm, h, tol, mstep, tcx, tcy;
  logic signed [CMP_W-1:0] ex, ey, step_x, step_y;
  logic                    required, finished, centred, mode_next;
  logic [PROD_W-1:0]       shrink_prod;
  logic                    take;

  assign ready_o = !out_valid_q || !out_stall_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    m     = $signed({{(CMP_W-MARGIN_W){1'b0}}, cfg_i.edge_margin});
    tm    = $signed({{(CMP_W-MARGIN_W){1'b0}}, cfg_i.top_edge_margin});
    h     = $signed({{(CMP_W-MARGIN_W){1'b0}}, cfg_i.hysteresis_margin});
    tol   = $signed({{(CMP_W-TOL_W){1'b0}}, cfg_i.center_tolerance});
    mstep = $signed({{(CMP_W-MSTEP_W){1'b0}}, cfg_i.move_step});
    tcx   = $signed({{(CMP_W-CENTER_W){1'b0}}, cfg_i.target_center_x});
    tcy   = $signed({{(CMP_W-CENTER_W){1'b0}}, cfg_i.target_center_y});

    required = (sx(rmin_x_i) < m) || (sx(rmin_y_i) < tm) ||
               (sx(rmax_x_i) > WIN_W_C - m) || (sx(rmax_y_i) > WIN_H_C - m);
    finished = (sx(rmin_x_i) >= m + h) && (sx(rmin_y_i) >= tm + h) &&
               (sx(rmax_x_i) < WIN_W_C - m - h) && (sx(rmax_y_i) < WIN_H_C - m - h);

    if (required && !mode_q) begin
      mode_next = 1'b1;
    end else if (finished && mode_q) begin
      mode_next = 1'b0;
    end else begin
      mode_next = mode_q;
    end

    ex      = tcx - sx(cen_x_i);
    ey      = tcy - sx(cen_y_i);
    centred = (sabs(ex) <= tol) && (sabs(ey) <= tol);
    step_x  = centred ? '0 : clamp_step(ex, mstep);
    step_y  = centred ? '0 : clamp_step(ey, mstep);

    shrink_prod = {{16{1'b0}}, factor_q} * {{FACTOR_W{1'b0}}, SHRINK_Q16};

    mode_d   = mode_q;
    factor_d = factor_q;
    action_d = ACT_NONE;
    if (cfg_i.option_on) begin
      mode_d = mode_next;
      if (mode_next) begin
        if (step_x != 0 || step_y != 0) begin
          action_d = ACT_MOVE;
        end else begin
          action_d = ACT_SHRINK;
          factor_d = shrink_prod[16 +: FACTOR_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
      factor_q    <= FACTOR_ONE;
    end else begin
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
      if (take) begin
        mode_q   <= mode_d;
        factor_q <= factor_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rmin_x_q     <= sat16(rmin_x_i);
      rmin_y_q     <= sat16(rmin_y_i);
      rmax_x_q     <= sat16(rmax_x_i);
      rmax_y_q     <= sat16(rmax_y_i);
      mode_out_q   <= mode_d;
      action_q     <= action_d;
      step_x_q     <= (action_d == ACT_MOVE) ? step_x[STEP_W-1:0] : '0;
      step_y_q     <= (action_d == ACT_MOVE) ? step_y[STEP_W-1:0] : '0;
      factor_out_q <= factor_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign box_min_x_real_o = rmin_x_q;
  assign box_min_y_real_o = rmin_y_q;
  assign box_max_x_real_o = rmax_x_q;
  assign box_max_y_real_o = rmax_y_q;
  assign rescale_on_o     = mode_out_q;
  assign action_o         = action_q;
  assign step_x_o         = step_x_q;
  assign step_y_o         = step_y_q;
  assign scale_factor_o   = factor_out_q;

  a_move_has_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && action_q == ACT_MOVE |-> step_x_q != 0 || step_y_q != 0)
    else $error("move result without a step");

  a_no_move_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && action_q != ACT_MOVE |-> step_x_q == 0 && step_y_q == 0)
    else $error("step reported without a move");

  a_action_needs_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && action_q != ACT_NONE |-> mode_out_q)
    else $error("command issued outside rescale mode");

  a_factor_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> factor_q <= $past(factor_q))
    else $error("cumulative factor grew");

endmodule

`default_nettype wire

// ===== test/bbox_autocenter_shrink_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounding-box autocentre and shrink testbench
// Streams line segments into the block under several register settings and
// idle patterns, predicts every frame report from its own copy of the box,
// the rescale mode and the shrink factor, and checks each report field by
// field in order of arrival.
// ----------------------------------------------------------------------------

module bbox_autocenter_shrink_tb;
  import bacs_pkg::*;

  localparam int WIN_W        = 1024;
  localparam int WIN_H        = 1024;
  localparam int ACC          = 16;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 85;
  localparam int NUM_PHASES   = 8;

  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] dx;
    logic signed [IN_W-1:0] dy;
    logic                   fs;
    logic                   fe;
  } seg_t;

  typedef struct {
    logic signed [REAL_W-1:0] min_x;
    logic signed [REAL_W-1:0] min_y;
    logic signed [REAL_W-1:0] max_x;
    logic signed [REAL_W-1:0] max_y;
    logic                     rescale;
    action_e                  act;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic [FACTOR_W-1:0]      factor;
  } frame_report_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i    = '0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic signed [IN_W-1:0]      x_pos_i       = '0;
  logic signed [IN_W-1:0]      y_pos_i       = '0;
  logic signed [IN_W-1:0]      delta_x_i     = '0;
  logic signed [IN_W-1:0]      delta_y_i     = '0;
  logic                        frame_start_i = 1'b0;
  logic                        frame_end_i   = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic signed [REAL_W-1:0]    box_min_x_real_o;
  logic signed [REAL_W-1:0]    box_min_y_real_o;
  logic signed [REAL_W-1:0]    box_max_x_real_o;
  logic signed [REAL_W-1:0]    box_max_y_real_o;
  logic                        rescale_on_o;
  logic [1:0]                  action_o;
  logic signed [STEP_W-1:0]    step_x_o;
  logic signed [STEP_W-1:0]    step_y_o;
  logic [FACTOR_W-1:0]         scale_factor_o;

  bbox_autocenter_shrink #(
    .WINDOW_WIDTH   (WIN_W),
    .WINDOW_HEIGHT  (WIN_H),
    .ACCURACY_SCALE (ACC)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .x_pos_i          (x_pos_i),
    .y_pos_i          (y_pos_i),
    .delta_x_i        (delta_x_i),
    .delta_y_i        (delta_y_i),
    .frame_start_i    (frame_start_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .box_min_x_real_o (box_min_x_real_o),
    .box_min_y_real_o (box_min_y_real_o),
    .box_max_x_real_o (box_max_x_real_o),
    .box_max_y_real_o (box_max_y_real_o),
    .rescale_on_o     (rescale_on_o),
    .action_o         (action_o),
    .step_x_o         (step_x_o),
    .step_y_o         (step_y_o),
    .scale_factor_o   (scale_factor_o)
  );

  seg_t          pending_segs[$];
  frame_report_t expected_reports[$];
  seg_t          bus_seg;
  seg_t          next_seg;

  cfg_t        model_cfg = CFG_RESET;
  int          lo_x, lo_y, hi_x, hi_y;
  bit          rescale_active;
  int unsigned scale_q16;

  int unsigned mismatches  = 0;
  int unsigned queued      = 0;
  int unsigned send_pct    = 0;
  int unsigned recv_pct    = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_given = 0;
  int unsigned hold_left   = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_box();
    lo_x = WIN_W * ACC;
    lo_y = WIN_H * ACC;
    hi_x = 0;
    hi_y = 0;
  endfunction

  function automatic logic signed [REAL_W-1:0] sat_window(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return REAL_W'(v);
  endfunction

  function automatic int clamp_move(int d, int s);
    if (d > s) return s;
    if (d < -s) return -s;
    return 0;
  endfunction

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic fold_segment(input seg_t s);
    int            ends [4];
    int            rminx, rminy, rmaxx, rmaxy;
    int            m, tm, h, ex, ey, tol, ms, sx, sy;
    bit            required, finished;
    action_e       act;
    frame_report_t r;
    ends[0] = int'(s.x);
    ends[1] = int'(s.x) + int'(s.dx);
    ends[2] = int'(s.y);
    ends[3] = int'(s.y) + int'(s.dy);
    if (s.fs) clear_box();
    for (int i = 0; i < 2; i++) begin
      if (lo_x > ends[i]) lo_x = ends[i];
      if (hi_x < ends[i]) hi_x = ends[i];
      if (lo_y > ends[i+2]) lo_y = ends[i+2];
      if (hi_y < ends[i+2]) hi_y = ends[i+2];
    end
    if (!s.fe) return;
    rminx = lo_x / ACC;
    rminy = lo_y / ACC;
    rmaxx = hi_x / ACC;
    rmaxy = hi_y / ACC;
    sx = 0;
    sy = 0;
    act = ACT_NONE;
    if (model_cfg.option_on) begin
      m  = int'(model_cfg.edge_margin);
      tm = int'(model_cfg.top_edge_margin);
      h  = int'(model_cfg.hysteresis_margin);
      required = rminx < m || rminy < tm || rmaxx > WIN_W - m || rmaxy > WIN_H - m;
      finished = rminx >= m + h && rminy >= tm + h &&
                 rmaxx < WIN_W - m - h && rmaxy < WIN_H - m - h;
      if (required && !rescale_active) rescale_active = 1'b1;
      else if (finished && rescale_active) rescale_active = 1'b0;
      if (rescale_active) begin
        ex  = int'(model_cfg.target_center_x) - (lo_x + hi_x) / 2;
        ey  = int'(model_cfg.target_center_y) - (lo_y + hi_y) / 2;
        tol = int'(model_cfg.center_tolerance);
        ms  = int'(model_cfg.move_step);
        if (!(abs_int(ex) <= tol && abs_int(ey) <= tol)) begin
          sx = clamp_move(ex, ms);
          sy = clamp_move(ey, ms);
        end
        if (sx != 0 || sy != 0) begin
          act = ACT_MOVE;
        end else begin
          act = ACT_SHRINK;
          scale_q16 = int'((64'(scale_q16) * SHRINK_Q16) >> 16);
        end
      end
    end
    r.min_x   = sat_window(rminx);
    r.min_y   = sat_window(rminy);
    r.max_x   = sat_window(rmaxx);
    r.max_y   = sat_window(rmaxy);
    r.rescale = rescale_active;
    r.act     = act;
    r.step_x  = STEP_W'(sx);
    r.step_y  = STEP_W'(sy);
    r.factor  = FACTOR_W'(scale_q16);
    expected_reports.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: offers the next pending segment, with random idle gaps, once the previous one has gone.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) fold_segment(bus_seg);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_segs.size() != 0 && $urandom_range(99) >= send_pct) begin
          next_seg = pending_segs.pop_front();
          bus_seg = next_seg;
          x_pos_i       <= next_seg.x;
          y_pos_i       <= next_seg.y;
          delta_x_i     <= next_seg.dx;
          delta_y_i     <= next_seg.dy;
          frame_start_i <= next_seg.fs;
          frame_end_i   <= next_seg.fe;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each report transfer and drives the stall.
  always @(posedge clk_i) begin
    frame_report_t r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report with none expected, min_x %0d max_x %0d", $time,
                   box_min_x_real_o, box_max_x_real_o);
          mismatches++;
        end else begin
          r = expected_reports.pop_front();
          compare_field("box_min_x_real", r.min_x, box_min_x_real_o);
          compare_field("box_min_y_real", r.min_y, box_min_y_real_o);
          compare_field("box_max_x_real", r.max_x, box_max_x_real_o);
          compare_field("box_max_y_real", r.max_y, box_max_y_real_o);
          compare_field("rescale_on", r.rescale, rescale_on_o);
          compare_field("action", r.act, action_o);
          compare_field("step_x", r.step_x, step_x_o);
          compare_field("step_y", r.step_y, step_y_o);
          compare_field("scale_factor", r.factor, scale_factor_o);
        end
      end
      if (holds_given != holds_asked) begin
        holds_given = holds_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_OPTION_ON:         model_cfg.option_on         = data[0];
      REG_EDGE_MARGIN:       model_cfg.edge_margin       = data[MARGIN_W-1:0];
      REG_TOP_EDGE_MARGIN:   model_cfg.top_edge_margin   = data[MARGIN_W-1:0];
      REG_HYSTERESIS_MARGIN: model_cfg.hysteresis_margin = data[MARGIN_W-1:0];
      REG_TARGET_CENTER_X:   model_cfg.target_center_x   = data[CENTER_W-1:0];
      REG_TARGET_CENTER_Y:   model_cfg.target_center_y   = data[CENTER_W-1:0];
      REG_MOVE_STEP:         model_cfg.move_step         = data[MSTEP_W-1:0];
      REG_CENTER_TOLERANCE:  model_cfg.center_tolerance  = data[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input cfg_t c);
    write_reg(REG_OPTION_ON, CFG_DATA_W'(c.option_on));
    write_reg(REG_EDGE_MARGIN, CFG_DATA_W'(c.edge_margin));
    write_reg(REG_TOP_EDGE_MARGIN, CFG_DATA_W'(c.top_edge_margin));
    write_reg(REG_HYSTERESIS_MARGIN, CFG_DATA_W'(c.hysteresis_margin));
    write_reg(REG_TARGET_CENTER_X, CFG_DATA_W'(c.target_center_x));
    write_reg(REG_TARGET_CENTER_Y, CFG_DATA_W'(c.target_center_y));
    write_reg(REG_MOVE_STEP, CFG_DATA_W'(c.move_step));
    write_reg(REG_CENTER_TOLERANCE, CFG_DATA_W'(c.center_tolerance));
  endtask

  task automatic drain();
    while (pending_segs.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void add_seg(int x, int y, int dx, int dy, bit fs, bit fe);
    seg_t s;
    s.x  = IN_W'(x);
    s.y  = IN_W'(y);
    s.dx = IN_W'(dx);
    s.dy = IN_W'(dy);
    s.fs = fs;
    s.fe = fe;
    pending_segs.push_back(s);
    queued++;
  endfunction

  // Segments with endpoints inside a box around (cx, cy).
  function automatic void add_frame(int n, int cx, int cy, int hw, int hh,
                                    bit start, bit finish);
    int x0, y0;
    for (int i = 0; i < n; i++) begin
      x0 = rand_between(cx - hw, cx + hw);
      y0 = rand_between(cy - hh, cy + hh);
      add_seg(x0, y0, rand_between(cx - hw, cx + hw) - x0,
              rand_between(cy - hh, cy + hh) - y0, start && i == 0, finish && i == n - 1);
    end
  endfunction

  function automatic void add_random_frame();
    int off, cx, cy, hw, hh, kind;
    case ($urandom_range(3))
      0: off = 16;
      1: off = int'(model_cfg.center_tolerance) + 8;
      2: off = 1000;
      default: off = 8000;
    endcase
    cx = clip(int'(model_cfg.target_center_x) + rand_between(-off, off), -120000, 120000);
    cy = clip(int'(model_cfg.target_center_y) + rand_between(-off, off), -120000, 120000);
    hw = ($urandom_range(3) == 0) ? rand_between(7000, 9000) : rand_between(0, 7000);
    hh = ($urandom_range(3) == 0) ? rand_between(7000, 9000) : rand_between(0, 7000);
    kind = $urandom_range(9);
    if (kind < 7) begin
      add_frame($urandom_range(1, 6), cx, cy, hw, hh, 1'b1, 1'b1);
    end else if (kind == 7) begin
      add_frame($urandom_range(1, 4), cx, cy, hw, hh, 1'b0, 1'b1);
    end else if (kind == 8) begin
      add_frame($urandom_range(1, 4), cx, cy, hw, hh, 1'b1, 1'b0);
    end else begin
      add_seg(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
              1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endfunction

  initial begin
    cfg_t c;
    clear_box();
    rescale_active = 1'b0;
    scale_q16 = int'(FACTOR_ONE);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed segments under the reset register values.
    add_seg(0, 0, 0, 0, 1'b0, 1'b1);
    add_seg(262143, 262143, 262143, 262143, 1'b1, 1'b1);
    add_seg(-262144, -262144, -262144, -262144, 1'b1, 1'b1);
    add_seg(-262144, 262143, 262143, -262144, 1'b1, 1'b1);
    add_seg(262143, -262144, -262144, 262143, 1'b1, 1'b1);
    add_seg(-17, -1, 0, 0, 1'b1, 1'b1);
    add_seg(100, 100, 16184, 16184, 1'b1, 1'b1);
    add_seg(16284, 16284, -16184, -16184, 1'b1, 1'b1);
    add_seg(120, 90, 16144, 16204, 1'b1, 1'b1);
    add_seg(8000, 8000, 400, 400, 1'b1, 1'b1);
    add_seg(3000, 9000, 500, -200, 1'b1, 1'b1);
    add_seg(5000, 9000, -4800, -8900, 1'b1, 1'b0);
    add_seg(3000, 3000, 100, 13000, 1'b0, 1'b0);
    add_seg(16000, 100, -200, 0, 1'b0, 1'b1);
    add_seg(320, 640, 15664, 15024, 1'b1, 1'b1);
    add_seg(640, 960, 14783, 14783, 1'b1, 1'b1);
    add_seg(8192, 8192, 0, 0, 1'b1, 1'b0);
    add_seg(8192, 8192, 0, 0, 1'b0, 1'b1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      c = CFG_RESET;
      case (p)
        1: c.option_on = 1'b0;
        2: begin
          c.edge_margin       = '0;
          c.top_edge_margin   = '0;
          c.hysteresis_margin = '0;
          c.target_center_x   = '0;
          c.target_center_y   = '0;
          c.move_step         = 13'd1;
          c.center_tolerance  = 14'd2;
        end
        3: begin
          c.edge_margin       = 10'd1023;
          c.top_edge_margin   = 10'd1023;
          c.hysteresis_margin = 10'd1023;
          c.target_center_x   = 18'd262143;
          c.target_center_y   = 18'd262143;
          c.move_step         = 13'd4096;
          c.center_tolerance  = 14'd8192;
        end
        4: begin
          c.move_step        = '0;
          c.center_tolerance = 14'd2;
        end
        5: begin
          c.move_step        = 13'd100;
          c.center_tolerance = 14'd10;
        end
        6, 7: begin
          c.option_on         = ($urandom_range(3) != 0);
          c.edge_margin       = MARGIN_W'($urandom_range(120));
          c.top_edge_margin   = MARGIN_W'($urandom_range(160));
          c.hysteresis_margin = MARGIN_W'($urandom_range(80));
          c.target_center_x   = CENTER_W'(rand_between(6000, 10000));
          c.target_center_y   = CENTER_W'(rand_between(6000, 10000));
          c.move_step         = MSTEP_W'($urandom_range(300));
          c.center_tolerance  = TOL_W'($urandom_range(600));
        end
        default: ;
      endcase
      apply_setup(c);
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 50; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 50; end
        default: begin send_pct = 22; recv_pct = 22; end
      endcase
      queued = 0;
      if (p == 4) begin
        // Long receiver hold-off while single-segment frames keep arriving.
        holds_asked++;
        for (int i = 0; i < 40; i++)
          add_frame(1, 8192, 8192, rand_between(0, 9000), rand_between(0, 9000), 1'b1, 1'b1);
      end
      while (queued < PHASE_ITEMS + ((p == 4) ? 40 : 0)) add_random_frame();
      drain();
    end

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
